// ===== src/pmar_pkg.sv =====
package pmar_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_META,
		ST_DIV1,
		ST_TEST,
		ST_RD_OLD,
		ST_DROP,
		ST_PUSH,
		ST_DIV2,
		ST_OUT
	} state_t;

	localparam int unsigned NUM_REGS  = 3;
	localparam logic [1:0]  REG_WIN   = 2'd0;
	localparam logic [1:0]  REG_THR   = 2'd1;
	localparam logic [1:0]  REG_STALE = 2'd2;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned SUM_W   = 22;
	localparam int unsigned FRAME_W = 16;
	localparam int unsigned CH_W    = 3;

	localparam logic [5:0]  WIN_RESET   = 6'd8;
	localparam logic [11:0] THR_RESET   = 12'd64;
	localparam logic [7:0]  STALE_RESET = 8'd3;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ===== src/pmar_div.sv =====
// Signed sum divided by an unsigned count, truncated toward zero, one quotient
// bit per cycle over three axes in parallel.
module pmar_div #(
	parameter int unsigned CNT_W = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [pmar_pkg::SUM_W-1:0]     num_x,
	input  logic signed [pmar_pkg::SUM_W-1:0]     num_y,
	input  logic signed [pmar_pkg::SUM_W-1:0]     num_z,
	input  logic [CNT_W-1:0]                      den,
	output pmar_pkg::div_ctl_t                    ctl,
	output logic signed [pmar_pkg::COORD_W-1:0]   quo_x,
	output logic signed [pmar_pkg::COORD_W-1:0]   quo_y,
	output logic signed [pmar_pkg::COORD_W-1:0]   quo_z
);
	localparam int unsigned SW  = pmar_pkg::SUM_W;
	localparam int unsigned CW  = $clog2(SW + 1);

	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SW-1:0]   mag_q [3];
	logic [SW-1:0]   rem_q [3];
	logic            neg_q [3];
	logic [CNT_W-1:0] den_q;
	logic [SW-1:0]   num_in [3];

	assign num_in[0] = num_x;
	assign num_in[1] = num_y;
	assign num_in[2] = num_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= num_in[i][SW-1];
				mag_q[i] <= num_in[i][SW-1] ? (~num_in[i] + 1'b1) : num_in[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				logic [SW:0] trial;
				trial = {rem_q[i], mag_q[i][SW-1]} - {{(SW+1-CNT_W){1'b0}}, den_q};
				if (!trial[SW]) begin
					rem_q[i] <= trial[SW-1:0];
					mag_q[i] <= {mag_q[i][SW-2:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i][SW-2:0], mag_q[i][SW-1]};
					mag_q[i] <= {mag_q[i][SW-2:0], 1'b0};
				end
			end
		end
	end

	logic [SW-1:0] sq [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			sq[i] = neg_q[i] ? (~mag_q[i] + 1'b1) : mag_q[i];
	end

	assign quo_x = sq[0][pmar_pkg::COORD_W-1:0];
	assign quo_y = sq[1][pmar_pkg::COORD_W-1:0];
	assign quo_z = sq[2][pmar_pkg::COORD_W-1:0];
	assign ctl   = '{start: start, busy: busy_q, done: done_q};
endmodule

// ===== src/pmar_hist_mem.sv =====
// Point history, one row per channel slot, synchronous read.
module pmar_hist_mem #(
	parameter int unsigned DEPTH  = 160,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  logic [3*pmar_pkg::COORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0]      raddr,
	output logic [3*pmar_pkg::COORD_W-1:0] rdata
);
	logic [3*pmar_pkg::COORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/point_moving_average_with_reset.sv =====
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    tdata: channel,pos_x,pos_y,pos_z,frame; tlast: end_of_call
// m_axis    out  m_tvalid/m_tready    tdata: out_channel,mean_x,mean_y,mean_z; tuser: mean_valid
// cfg       in   cfg_we               cfg_idx, cfg_data
//
// One item at a time. A point that joins a nonempty history takes two passes of the
// 22-step shift-subtract divider: mean for the jump test, then mean of the result.
// Only the second pass runs for a point into an empty history or for no update on a
// nonempty one; an out-of-range channel or an empty history with no update skips both.
// The result sits in an output register, so the next transfer is taken while it waits;
// a downstream stall holds only the final step. Reset clears all per-channel metadata
// flip-flops; the history memory is not cleared and needs no sweep.
module point_moving_average_with_reset #(
	parameter int unsigned NUM_CHANNELS  = 5,
	parameter int unsigned HISTORY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel[2:0], pos_x[18:3], pos_y[34:19], pos_z[50:35], frame_number[66:51], pad
	input  logic [71:0] s_tdata,
	// end_of_call
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_channel[2:0], mean_x[18:3], mean_y[34:19], mean_z[50:35], pad
	output logic [55:0] m_tdata,
	// mean_valid
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data
);
	localparam int unsigned HW   = $clog2(HISTORY_DEPTH);
	localparam int unsigned FW   = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned MD   = NUM_CHANNELS * HISTORY_DEPTH;
	localparam int unsigned MAW  = $clog2(MD);
	localparam int unsigned CW   = pmar_pkg::COORD_W;
	localparam int unsigned SW   = pmar_pkg::SUM_W;
	localparam int unsigned FRW  = pmar_pkg::FRAME_W;

	pmar_pkg::state_t st_q, st_d;

	logic [5:0]  win_q;
	logic [11:0] thr_q;
	logic [7:0]  stale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= pmar_pkg::WIN_RESET;
			thr_q   <= pmar_pkg::THR_RESET;
			stale_q <= pmar_pkg::STALE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				pmar_pkg::REG_WIN:   win_q   <= cfg_data[5:0];
				pmar_pkg::REG_THR:   thr_q   <= cfg_data;
				pmar_pkg::REG_STALE: stale_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// per-channel metadata
	logic [HW-1:0]         head_q  [NUM_CHANNELS];
	logic [FW-1:0]         fill_q  [NUM_CHANNELS];
	logic signed [SW-1:0]  sx_q    [NUM_CHANNELS];
	logic signed [SW-1:0]  sy_q    [NUM_CHANNELS];
	logic signed [SW-1:0]  sz_q    [NUM_CHANNELS];
	logic [FRW-1:0]        luf_q   [NUM_CHANNELS];
	logic [FRW-1:0]        cfrm_q;
	logic                  seen_q;

	// item registers
	logic [2:0]            ch_q;
	logic [CHW-1:0]        chi_q;
	logic signed [CW-1:0]  px_q, py_q, pz_q;
	logic [FRW-1:0]        frm_q;
	logic                  eoc_q;
	logic                  inr_q;
	logic                  upd_q;
	logic [HW-1:0]         head_w_q;
	logic [FW-1:0]         fill_w_q;
	logic signed [SW-1:0]  wx_q, wy_q, wz_q;

	logic [FW-1:0] win_eff;
	always_comb begin
		if (win_q == 6'd0)
			win_eff = FW'(1);
		else if (32'(win_q) > HISTORY_DEPTH)
			win_eff = FW'(HISTORY_DEPTH);
		else
			win_eff = FW'(win_q);
	end

	// divider
	pmar_pkg::div_ctl_t dctl;
	logic signed [CW-1:0] qx, qy, qz;
	logic                 div_go;

	pmar_div #(.CNT_W(FW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num_x(wx_q), .num_y(wy_q), .num_z(wz_q), .den(fill_w_q),
		.ctl(dctl), .quo_x(qx), .quo_y(qy), .quo_z(qz)
	);

	// history memory
	logic             mem_we;
	logic [MAW-1:0]   mem_waddr, mem_raddr;
	logic [3*CW-1:0]  mem_rdata;

	pmar_hist_mem #(.DEPTH(MD), .ADDR_W(MAW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr),
		.wdata({pz_q, py_q, px_q}), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	// head + fill stays below twice the depth, so one subtract wraps it
	logic [FW:0]   slot_sum;
	logic [HW-1:0] wslot;
	assign slot_sum  = (FW+1)'(head_w_q) + (FW+1)'(fill_w_q);
	assign wslot     = (slot_sum >= (FW+1)'(HISTORY_DEPTH))
		? HW'(slot_sum - (FW+1)'(HISTORY_DEPTH)) : HW'(slot_sum);
	assign mem_raddr = MAW'(32'(chi_q) * HISTORY_DEPTH + 32'(head_w_q));
	assign mem_waddr = MAW'(32'(chi_q) * HISTORY_DEPTH + 32'(wslot));
	assign mem_we    = (st_q == pmar_pkg::ST_PUSH);

	// squared distance, registered per axis
	logic [33:0] d2_s1 [3];
	logic signed [CW:0] dd [3];
	logic signed [2*CW+1:0] sqd [3];
	always_comb begin
		dd[0] = {px_q[CW-1], px_q} - {qx[CW-1], qx};
		dd[1] = {py_q[CW-1], py_q} - {qy[CW-1], qy};
		dd[2] = {pz_q[CW-1], pz_q} - {qz[CW-1], qz};
		for (int i = 0; i < 3; i++)
			sqd[i] = dd[i] * dd[i];
	end

	logic [35:0] d2sum;
	assign d2sum = 36'(d2_s1[0]) + 36'(d2_s1[1]) + 36'(d2_s1[2]);

	logic jump;
	assign jump = d2sum > 36'(thr_q) * 36'(thr_q);

	logic                  m_valid_q;
	logic [55:0]           m_data_q;
	logic                  m_user_q;
	logic                  out_go;

	logic [2:0] in_ch;
	assign in_ch    = s_tdata[2:0];
	assign s_tready = (st_q == pmar_pkg::ST_IDLE);
	// finish only once the output register is free or being emptied
	assign out_go   = (st_q == pmar_pkg::ST_OUT) && (!m_valid_q || m_tready);

	always_comb begin
		st_d   = st_q;
		div_go = 1'b0;
		case (st_q)
			pmar_pkg::ST_IDLE:
				if (s_tvalid && s_tready) st_d = pmar_pkg::ST_RD_META;
			pmar_pkg::ST_RD_META: begin
				if (!inr_q)
					st_d = pmar_pkg::ST_OUT;
				else if (upd_q && fill_q[chi_q] != '0)
					st_d = pmar_pkg::ST_DIV1;
				else if (upd_q)
					st_d = pmar_pkg::ST_RD_OLD;
				else if (fill_q[chi_q] != '0)
					st_d = pmar_pkg::ST_DIV2;
				else
					st_d = pmar_pkg::ST_OUT;
			end
			pmar_pkg::ST_DIV1:
				if (dctl.done) st_d = pmar_pkg::ST_TEST;
				else if (!dctl.busy) div_go = 1'b1;
			pmar_pkg::ST_TEST:
				st_d = pmar_pkg::ST_RD_OLD;
			pmar_pkg::ST_RD_OLD:
				st_d = pmar_pkg::ST_DROP;
			pmar_pkg::ST_DROP:
				st_d = pmar_pkg::ST_PUSH;
			pmar_pkg::ST_PUSH:
				st_d = pmar_pkg::ST_DIV2;
			pmar_pkg::ST_DIV2:
				if (dctl.done) st_d = pmar_pkg::ST_OUT;
				else if (!dctl.busy) div_go = 1'b1;
			pmar_pkg::ST_OUT:
				if (!m_valid_q || m_tready) st_d = pmar_pkg::ST_IDLE;
			default:
				st_d = pmar_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pmar_pkg::ST_IDLE;
			m_valid_q   <= 1'b0;
			cfrm_q      <= '0;
			seen_q      <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				head_q[c] <= '0;
				fill_q[c] <= '0;
				sx_q[c]   <= '0;
				sy_q[c]   <= '0;
				sz_q[c]   <= '0;
				luf_q[c]  <= '0;
			end
		end else begin
			st_q <= st_d;
			if (out_go)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			if (out_go) begin
				if (inr_q) begin
					head_q[chi_q] <= head_w_q;
					fill_q[chi_q] <= fill_w_q;
					sx_q[chi_q]   <= wx_q;
					sy_q[chi_q]   <= wy_q;
					sz_q[chi_q]   <= wz_q;
					if (upd_q) luf_q[chi_q] <= frm_q;
				end
				if (eoc_q) begin
					cfrm_q <= frm_q;
					seen_q <= 1'b1;
				end
			end
		end
	end

	logic [FRW-1:0] age;
	logic           ok;
	assign age = frm_q - (upd_q ? frm_q : luf_q[chi_q]);
	assign ok  = inr_q && (fill_w_q != '0) && (age < FRW'(stale_q));

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_q  <= in_ch;
			chi_q <= CHW'(in_ch);
			px_q  <= s_tdata[18:3];
			py_q  <= s_tdata[34:19];
			pz_q  <= s_tdata[50:35];
			frm_q <= s_tdata[66:51];
			eoc_q <= s_tlast;
			inr_q <= 32'(in_ch) < NUM_CHANNELS;
			upd_q <= (s_tdata[50:3] != '0)
				&& (!seen_q || cfrm_q != s_tdata[66:51]);
		end
		if (st_q == pmar_pkg::ST_RD_META) begin
			head_w_q <= head_q[chi_q];
			fill_w_q <= fill_q[chi_q];
			wx_q     <= sx_q[chi_q];
			wy_q     <= sy_q[chi_q];
			wz_q     <= sz_q[chi_q];
		end
		// far from the mean: drop the history
		if (st_q == pmar_pkg::ST_TEST && jump) begin
			fill_w_q <= '0;
			head_w_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
			wz_q <= '0;
		end
		if (st_q == pmar_pkg::ST_DROP && fill_w_q >= win_eff) begin
			wx_q     <= wx_q - SW'($signed(mem_rdata[CW-1:0]));
			wy_q     <= wy_q - SW'($signed(mem_rdata[2*CW-1:CW]));
			wz_q     <= wz_q - SW'($signed(mem_rdata[3*CW-1:2*CW]));
			head_w_q <= (head_w_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_w_q + 1'b1;
			fill_w_q <= fill_w_q - 1'b1;
		end
		if (st_q == pmar_pkg::ST_PUSH) begin
			wx_q     <= wx_q + SW'(px_q);
			wy_q     <= wy_q + SW'(py_q);
			wz_q     <= wz_q + SW'(pz_q);
			fill_w_q <= fill_w_q + 1'b1;
		end
		if (st_q == pmar_pkg::ST_DIV1 && dctl.done) begin
			for (int i = 0; i < 3; i++)
				d2_s1[i] <= $unsigned(sqd[i]);
		end
		if (out_go) begin
			m_user_q <= ok;
			m_data_q <= {5'd0, ok ? qz : 16'sd0, ok ? qy : 16'sd0,
				ok ? qx : 16'sd0, ch_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
endmodule

// ===== src/pmar_check.sv =====
module pmar_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[50:3] == '0)
		else $error("invalid mean not zero");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");
endmodule

bind point_moving_average_with_reset pmar_check u_check (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== test/point_average_checker.sv =====
module point_average_checker (
	input  logic        clk,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS = 5;
	localparam int DEPTH    = 32;

	typedef struct packed {
		logic [2:0]         chan;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
		logic               valid;
	} mean_t;

	logic signed [15:0] ring [CHANNELS][DEPTH][3];
	int                 head [CHANNELS];
	int                 fill [CHANNELS];
	longint             acc  [CHANNELS][3];
	logic [15:0]        upd_frame [CHANNELS];
	logic [15:0]        last_frame;
	logic               frame_known;
	logic [5:0]         win_reg;
	logic [11:0]        thr_reg;
	logic [7:0]         stale_reg;

	mean_t means_due[$];

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			head[c] = 0;
			fill[c] = 0;
			upd_frame[c] = '0;
			for (int a = 0; a < 3; a++)
				acc[c][a] = 0;
		end
		last_frame  = '0;
		frame_known = 1'b0;
		win_reg     = pmar_pkg::WIN_RESET;
		thr_reg     = pmar_pkg::THR_RESET;
		stale_reg   = pmar_pkg::STALE_RESET;
		errors      = 0;
	end

	assign pending = means_due.size();

	function automatic mean_t average_point(logic [71:0] d, logic eoc);
		mean_t       r;
		int          ch, n, w, win;
		longint      p [3];
		longint      diff, d2, t2;
		logic [15:0] frame, age;
		ch    = d[2:0];
		p[0]  = $signed(d[18:3]);
		p[1]  = $signed(d[34:19]);
		p[2]  = $signed(d[50:35]);
		frame = d[66:51];
		r     = '0;
		r.chan = d[2:0];
		if (ch < CHANNELS) begin
			if ((p[0] != 0 || p[1] != 0 || p[2] != 0) &&
			    (!frame_known || last_frame != frame)) begin
				win = (win_reg == 0) ? 1 : (win_reg > DEPTH) ? DEPTH : int'(win_reg);
				if (fill[ch] != 0) begin
					n  = fill[ch];
					d2 = 0;
					for (int a = 0; a < 3; a++) begin
						diff = p[a] - acc[ch][a] / n;
						d2  += diff * diff;
					end
					t2 = longint'(thr_reg) * longint'(thr_reg);
					// far from the mean: discard the history
					if (d2 > t2) begin
						fill[ch] = 0;
						head[ch] = 0;
						for (int a = 0; a < 3; a++)
							acc[ch][a] = 0;
					end
				end
				if (fill[ch] >= win) begin
					for (int a = 0; a < 3; a++)
						acc[ch][a] -= ring[ch][head[ch]][a];
					head[ch] = (head[ch] + 1) % DEPTH;
					fill[ch]--;
				end
				w = (head[ch] + fill[ch]) % DEPTH;
				for (int a = 0; a < 3; a++) begin
					ring[ch][w][a] = p[a][15:0];
					acc[ch][a] += p[a];
				end
				fill[ch]++;
				upd_frame[ch] = frame;
			end
			if (fill[ch] != 0) begin
				age = frame - upd_frame[ch];
				if (age < stale_reg) begin
					n       = fill[ch];
					r.valid = 1'b1;
					r.mx    = 16'(acc[ch][0] / n);
					r.my    = 16'(acc[ch][1] / n);
					r.mz    = 16'(acc[ch][2] / n);
				end
			end
		end
		if (eoc) begin
			last_frame  = frame;
			frame_known = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		mean_t want, got;
		if (cfg_we) begin
			case (cfg_idx)
				pmar_pkg::REG_WIN:   win_reg   = cfg_data[5:0];
				pmar_pkg::REG_THR:   thr_reg   = cfg_data;
				pmar_pkg::REG_STALE: stale_reg = cfg_data[7:0];
				default: ;
			endcase
		end
		if (s_tvalid && s_tready)
			means_due = {means_due, average_point(s_tdata, s_tlast)};
		if (m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tdata[50:35], m_tuser};
			if (means_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: ch %0d mean %0d %0d %0d valid %0b",
						got.chan, got.mx, got.my, got.mz, got.valid);
			end else begin
				want = means_due.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp ch %0d %0d %0d %0d v%0b, got ch %0d %0d %0d %0d v%0b",
							want.chan, want.mx, want.my, want.mz, want.valid,
							got.chan, got.mx, got.my, got.mz, got.valid);
				end
			end
		end
	end
endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN       = 80;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [11:0] cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	int          stall;
	logic        calm;
	logic [15:0] frame;
	logic signed [15:0] track [5][3];

	point_moving_average_with_reset dut (.*);

	point_average_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// downstream backpressure
	initial begin
		m_tready = 1'b0;
		stall    = 0;
	end
	always @(negedge clk) begin
		if (stall > 0) begin
			m_tready = 1'b0;
			stall--;
		end else begin
			m_tready = 1'b1;
			if ($urandom_range(0, 7) == 0)
				stall = pick_gap();
		end
	end

	task automatic send(input logic [2:0] ch, input logic [15:0] x, input logic [15:0] y,
	                    input logic [15:0] z, input logic [15:0] fr, input logic eoc);
		int g;
		s_tdata  = {5'b0, fr, z, y, x, ch};
		s_tlast  = eoc;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		g = pick_gap();
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	// drain outstanding means, then let the datapath settle before a write
	task automatic settle();
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic [15:0] jitter(logic signed [15:0] base, int spread);
		return base + 16'($signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// one call: channels 0 up to a random last one in order, same frame, end marked on the last
	task automatic send_call(int spread);
		int last;
		last = $urandom_range(0, 4);
		for (int c = 0; c <= last; c++) begin
			if ($urandom_range(0, 29) == 0)
				for (int a = 0; a < 3; a++)
					track[c][a] = 16'($urandom);
			if ($urandom_range(0, 19) == 0)
				send(3'(c), 16'h0, 16'h0, 16'h0, frame, c == last);
			else
				send(3'(c), jitter(track[c][0], spread), jitter(track[c][1], spread),
					jitter(track[c][2], spread), frame, c == last);
		end
	endtask

	initial begin
		logic [11:0] win_v  [8] = '{12'd8, 12'd1, 12'd32, 12'd0, 12'd63, 12'd5, 12'd33, 12'd3};
		logic [11:0] thr_v  [8] = '{12'd64, 12'd0, 12'd4095, 12'd4095, 12'd100, 12'd2000,
		                            12'd300, 12'd2730};
		logic [11:0] stale_v[8] = '{12'd3, 12'd1, 12'd255, 12'd0, 12'd5, 12'd2, 12'd128,
		                            12'd170};
		int r;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		calm     = 1'b0;
		for (int c = 0; c < 5; c++)
			for (int a = 0; a < 3; a++)
				track[c][a] = 16'($urandom);
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings
		send(3'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b0);
		send(3'd0, 16'h7ff0, 16'h7ff8, 16'h7fff, 16'd0, 1'b0);
		send(3'd1, 16'h8000, 16'h8000, 16'h8000, 16'd0, 1'b0);
		send(3'd2, 16'h0000, 16'h0000, 16'h0000, 16'd0, 1'b0);
		send(3'd7, 16'h1234, 16'h0001, 16'hffff, 16'd0, 1'b1);
		send(3'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b0);
		send(3'd1, 16'h8000, 16'h8000, 16'h8000, 16'd1, 1'b0);
		send(3'd1, 16'h0000, 16'h8000, 16'h0000, 16'd1, 1'b0);
		send(3'd5, 16'h0001, 16'h0001, 16'h0001, 16'd1, 1'b0);
		send(3'd6, 16'h0001, 16'h0001, 16'h0001, 16'd1, 1'b1);
		send(3'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd3, 1'b1);
		send(3'd1, 16'h8001, 16'h8000, 16'h8000, 16'd3, 1'b1);
		send(3'd0, 16'h0000, 16'h0000, 16'h0001, 16'd65535, 1'b1);
		send(3'd0, 16'h0000, 16'h0000, 16'h0002, 16'd1, 1'b0);
		send(3'd4, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 1'b0);
		send(3'd4, 16'hfffe, 16'h0001, 16'h0000, 16'h0000, 1'b1);
		send(3'd3, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1);
		send(3'd3, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0);
		settle();
		write_reg(2'(pmar_pkg::NUM_REGS), 12'hfff);

		frame = 16'($urandom);
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(pmar_pkg::REG_WIN, win_v[ph]);
			write_reg(pmar_pkg::REG_THR, thr_v[ph]);
			write_reg(pmar_pkg::REG_STALE, stale_v[ph]);
			calm = (ph % 3 == 2);
			for (int k = 0; k < 93; k++) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					send_call((r < 8) ? 4000 : int'(thr_v[ph] / 2) + 1);
					r = $urandom_range(0, 99);
					if (r < 75)
						frame++;
					else if (r < 85)
						frame = frame + 16'($urandom_range(2, 300));
					else if (r < 90)
						frame = 16'($urandom);
				end else begin
					send(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						(r < 90) ? frame : 16'($urandom), 1'($urandom));
				end
			end
		end

		settle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
